>>> design/segment_subdivider_assert.svh
// Assertion macros used by the segment subdivider checker.
`ifndef SEGMENT_SUBDIVIDER_ASSERT_SVH
`define SEGMENT_SUBDIVIDER_ASSERT_SVH

// Same-cycle implication, sampled on clock, off during reset.
`define SUB_ASSERT_NOW(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("segment_subdivider check failed");

// Next-cycle implication, sampled on clock, off during reset.
`define SUB_ASSERT_NEXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("segment_subdivider check failed");

`endif

>>> design/sub_pkg.sv
// Shared types and constants of the segment subdivider.
package sub_pkg;
   localparam int VTX_W   = 21;
   localparam int SEG_W   = 24;
   localparam int CSEG_W  = 20;
   localparam int COORD_W = 32;
   localparam int POS_W   = 17;
   localparam int PIECE_W = 7;
   localparam int CNT_W   = 32;
   localparam int QUEUE_DEPTH = 2;
   localparam int DIV_W   = 34;
   localparam int DEN_W   = 8;

   localparam logic CMD_SEGMENT = 1'b0;
   localparam logic CMD_POINT   = 1'b1;
   localparam logic KIND_SEGMENT = 1'b0;
   localparam logic KIND_POINT   = 1'b1;

   localparam logic [POS_W-1:0] Q_ONE = POS_W'(65536);

   typedef struct packed {
      logic                      is_point;
      logic [CSEG_W-1:0]         cseg;
      logic [CSEG_W-1:0]         cf;
      logic [CSEG_W-1:0]         ct;
      logic signed [COORD_W-1:0] sx;
      logic signed [COORD_W-1:0] sy;
      logic signed [COORD_W-1:0] ex;
      logic signed [COORD_W-1:0] ey;
      logic [PIECE_W-1:0]        n;
      logic [CNT_W-1:0]          nv;
      logic [CNT_W-1:0]          base;
      logic [POS_W-1:0]          pos;
   } item_type;

   typedef struct packed {
      logic                      kind;
      logic [CSEG_W-1:0]         coarse_segment;
      logic [VTX_W-1:0]          fine_from;
      logic [VTX_W-1:0]          fine_to;
      logic                      new_vertex;
      logic signed [COORD_W-1:0] vertex_x;
      logic signed [COORD_W-1:0] vertex_y;
      logic [POS_W-1:0]          vertex_pos;
      logic [SEG_W-1:0]          fine_segment;
      logic [POS_W-1:0]          fine_point_pos;
      logic                      last;
      logic                      error;
   } result_type;
endpackage

>>> design/sub_channels.sv
// Channel interfaces of the segment subdivider: request, response, register write.
interface sub_req_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      command;
   logic [sub_pkg::CSEG_W-1:0]                coarse_from;
   logic [sub_pkg::CSEG_W-1:0]                coarse_to;
   logic signed [sub_pkg::COORD_W-1:0]        start_x;
   logic signed [sub_pkg::COORD_W-1:0]        start_y;
   logic signed [sub_pkg::COORD_W-1:0]        end_x;
   logic signed [sub_pkg::COORD_W-1:0]        end_y;
   logic [sub_pkg::PIECE_W-1:0]               pieces;
   logic [sub_pkg::POS_W-1:0]                 point_pos;
   modport source (output valid, command, coarse_from, coarse_to, start_x, start_y,
                   end_x, end_y, pieces, point_pos, input ready);
   modport sink (input valid, command, coarse_from, coarse_to, start_x, start_y,
                 end_x, end_y, pieces, point_pos, output ready);
endinterface

interface sub_rsp_if;
   logic                                      valid;
   logic                                      ready;
   logic                                      kind;
   logic [sub_pkg::CSEG_W-1:0]                coarse_segment;
   logic [sub_pkg::VTX_W-1:0]                 fine_from;
   logic [sub_pkg::VTX_W-1:0]                 fine_to;
   logic                                      new_vertex;
   logic signed [sub_pkg::COORD_W-1:0]        vertex_x;
   logic signed [sub_pkg::COORD_W-1:0]        vertex_y;
   logic [sub_pkg::POS_W-1:0]                 vertex_pos;
   logic [sub_pkg::SEG_W-1:0]                 fine_segment;
   logic [sub_pkg::POS_W-1:0]                 fine_point_pos;
   logic                                      last;
   logic                                      error;
   modport source (output valid, kind, coarse_segment, fine_from, fine_to, new_vertex,
                   vertex_x, vertex_y, vertex_pos, fine_segment, fine_point_pos, last,
                   error, input ready);
   modport sink (input valid, kind, coarse_segment, fine_from, fine_to, new_vertex,
                 vertex_x, vertex_y, vertex_pos, fine_segment, fine_point_pos, last,
                 error, output ready);
endinterface

interface sub_csr_if;
   logic                        valid;
   logic                        ready;
   logic [sub_pkg::VTX_W-1:0]   data;
   modport source (output valid, data, input ready);
   modport sink (input valid, data, output ready);
endinterface

>>> design/segment_subdivider.sv
// Top level of the segment subdivider: front end, work queue, back end.
// A coarse segment of n pieces is loaded, then runs through a serial divider (one
// quotient bit per cycle, for the x step, the y step and the position step), and then
// emits one fine segment per cycle whenever the response register is free; a data
// point is mapped without the divider. A zero-piece segment is absorbed by the front
// end. A two-entry queue sits between the front end and the back end, and the
// response register lets the back end start the next item while a result beat waits
// to be taken.
module segment_subdivider #(
   parameter int MAX_PIECES   = 64,
   parameter int VERTEX_BITS  = 21,
   parameter int SEGMENT_BITS = 24
) (
   input logic        clock,
   input logic        reset,
   sub_req_if.sink    req_bus,
   sub_rsp_if.source  rsp_bus,
   sub_csr_if.sink    csr_bus
);
   logic              push_valid, push_ready, pop_valid, pop_ready;
   sub_pkg::item_type push_item, pop_item;

   sub_front #(
      .MAX_PIECES   (MAX_PIECES),
      .VERTEX_BITS  (VERTEX_BITS),
      .SEGMENT_BITS (SEGMENT_BITS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr        (csr_bus),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item)
   );

   sub_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   sub_back #(
      .VERTEX_BITS  (VERTEX_BITS),
      .SEGMENT_BITS (SEGMENT_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_item  (pop_item),
      .rsp       (rsp_bus)
   );
endmodule

>>> design/sub_front.sv
// Front end: accepts beats, tracks segment counters, queues work items.
module sub_front #(
   parameter int MAX_PIECES   = 64,
   parameter int VERTEX_BITS  = 21,
   parameter int SEGMENT_BITS = 24
) (
   input  logic                clock,
   input  logic                reset,
   sub_req_if.sink             req,
   sub_csr_if.sink             csr,
   output logic                push_valid,
   input  logic                push_ready,
   output sub_pkg::item_type   push_item
);
   logic [sub_pkg::CSEG_W-1:0]  seg_idx_ff, seg_idx_in;
   logic [sub_pkg::PIECE_W-1:0] cur_n_ff, cur_n_in;
   logic [SEGMENT_BITS-1:0]     base_ff, base_in;
   logic [SEGMENT_BITS-1:0]     fsc_ff, fsc_in;
   logic [VERTEX_BITS-1:0]      nv_ff, nv_in;
   logic [sub_pkg::PIECE_W-1:0] n_sat;
   logic                        take;

   assign req.ready = push_ready;
   assign csr.ready = 1'b1;
   assign take      = req.valid && push_ready;
   assign n_sat     = (req.pieces > sub_pkg::PIECE_W'(MAX_PIECES)) ?
                      sub_pkg::PIECE_W'(MAX_PIECES) : req.pieces;

   always_comb begin
      seg_idx_in = seg_idx_ff;
      cur_n_in   = cur_n_ff;
      base_in    = base_ff;
      fsc_in     = fsc_ff;
      nv_in      = nv_ff;
      push_valid = 1'b0;
      push_item  = '0;
      push_item.is_point = (req.command == sub_pkg::CMD_POINT);
      push_item.cf   = req.coarse_from;
      push_item.ct   = req.coarse_to;
      push_item.sx   = req.start_x;
      push_item.sy   = req.start_y;
      push_item.ex   = req.end_x;
      push_item.ey   = req.end_y;
      push_item.pos  = req.point_pos;
      push_item.nv   = sub_pkg::CNT_W'(nv_ff);
      if (req.command == sub_pkg::CMD_POINT) begin
         push_item.cseg = seg_idx_ff;
         push_item.n    = cur_n_ff;
         push_item.base = sub_pkg::CNT_W'(base_ff);
         push_valid     = req.valid;
      end else begin
         push_item.cseg = seg_idx_ff + 1'b1;
         push_item.n    = n_sat;
         push_item.base = sub_pkg::CNT_W'(fsc_ff);
         push_valid     = req.valid && (n_sat != '0);
         if (take) begin
            seg_idx_in = seg_idx_ff + 1'b1;
            cur_n_in   = n_sat;
            base_in    = fsc_ff;
            if (n_sat != '0) begin
               nv_in  = nv_ff + VERTEX_BITS'(n_sat) - VERTEX_BITS'(1);
               fsc_in = fsc_ff + SEGMENT_BITS'(n_sat);
            end
         end
      end
      if (csr.valid) begin
         nv_in = VERTEX_BITS'(csr.data);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_idx_ff <= '1;
         cur_n_ff   <= '0;
         base_ff    <= '0;
         fsc_ff     <= '0;
         nv_ff      <= '0;
      end else begin
         seg_idx_ff <= seg_idx_in;
         cur_n_ff   <= cur_n_in;
         base_ff    <= base_in;
         fsc_ff     <= fsc_in;
         nv_ff      <= nv_in;
      end
   end
endmodule

>>> design/sub_queue.sv
// Two-entry work queue between front and back.
module sub_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  sub_pkg::item_type  push_item,
   output logic               pop_valid,
   input  logic               pop_ready,
   output sub_pkg::item_type  pop_item
);
   localparam int PTR_W = $clog2(sub_pkg::QUEUE_DEPTH);
   localparam int CNT_QW = $clog2(sub_pkg::QUEUE_DEPTH + 1);

   sub_pkg::item_type   mem_ff [sub_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_QW-1:0]   cnt_ff, cnt_in;
   logic                do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_QW'(sub_pkg::QUEUE_DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_item   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(sub_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(sub_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end
endmodule

>>> design/sub_back.sv
// Back end: serial divider, piece stepping, point mapping, response register.
module sub_back #(
   parameter int VERTEX_BITS  = 21,
   parameter int SEGMENT_BITS = 24
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  sub_pkg::item_type  pop_item,
   sub_rsp_if.source          rsp
);
   typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_EMIT, ST_POINT} state_type;

   localparam int DW = sub_pkg::DIV_W;
   localparam int NW = sub_pkg::DEN_W;
   localparam int CW = sub_pkg::COORD_W;

   state_type               state_ff, state_in;
   sub_pkg::item_type       cur_ff, cur_in;
   sub_pkg::result_type     out_ff, out_in;
   logic                    out_valid_ff, out_valid_in;
   logic [1:0]              sel_ff, sel_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic [DW-1:0]           dnum_ff, dnum_in;
   logic [NW-1:0]           drem_ff, drem_in;
   logic                    dneg_ff, dneg_in;
   logic [CW-1:0]           stq_ff [3];
   logic [CW-1:0]           stq_in [3];
   logic [NW-1:0]           str_ff [3];
   logic [NW-1:0]           str_in [3];
   logic [CW-1:0]           acc_ff [3];
   logic [CW-1:0]           acc_in [3];
   logic [NW-1:0]           res_ff [3];
   logic [NW-1:0]           res_in [3];
   logic [CW-1:0]           acc_nx [3];
   logic [NW-1:0]           res_nx [3];
   logic [sub_pkg::PIECE_W-1:0] j_ff, j_in;
   logic [VERTEX_BITS-1:0]  vcur_ff, vcur_in, vprev;
   logic [SEGMENT_BITS-1:0] seg_ff, seg_in, pseg;
   logic [NW-1:0]           den;
   logic                    out_free, fin;
   logic [NW:0]             rem_sh, rem_sub;
   logic                    ge;
   logic [DW-1:0]           q_mag;
   logic [NW-1:0]           r_fin;
   logic [CW-1:0]           q_fix;
   logic [NW-1:0]           r_fix;
   logic [DW-1:0]           ld_mag;
   logic                    ld_neg;
   logic [1:0]              ld_sel;
   logic [sub_pkg::PIECE_W+sub_pkg::POS_W-1:0] tn, frac;
   logic [NW-1:0]           ll;

   function automatic logic [DW:0] dividend(input logic [1:0] sel,
                                            input sub_pkg::item_type it);
      logic signed [DW-1:0] d;
      begin
         case (sel)
            2'd0:    d = ({{2{it.ex[CW-1]}}, it.ex} - {{2{it.sx[CW-1]}}, it.sx}) <<< 1;
            2'd1:    d = ({{2{it.ey[CW-1]}}, it.ey} - {{2{it.sy[CW-1]}}, it.sy}) <<< 1;
            default: d = DW'(2 * 65536);
         endcase
         dividend = {d[DW-1], d[DW-1] ? -d : d};
      end
   endfunction

   assign den       = {cur_ff.n, 1'b0};
   assign out_free  = !out_valid_ff || rsp.ready;
   assign pop_ready = (state_ff == ST_IDLE);
   assign fin       = ((j_ff + 1'b1) == cur_ff.n);
   assign vprev     = vcur_ff - VERTEX_BITS'(1);

   assign rem_sh  = {drem_ff, dnum_ff[DW-1]};
   assign ge      = (rem_sh >= {1'b0, den});
   assign rem_sub = rem_sh - {1'b0, den};
   assign q_mag   = {dnum_ff[DW-2:0], ge};
   assign r_fin   = ge ? rem_sub[NW-1:0] : rem_sh[NW-1:0];
   assign q_fix   = !dneg_ff ? q_mag[CW-1:0] :
                    (r_fin != '0) ? ~q_mag[CW-1:0] : -q_mag[CW-1:0];
   assign r_fix   = (dneg_ff && r_fin != '0) ? den - r_fin : r_fin;
   assign ld_sel  = (state_ff == ST_IDLE) ? 2'd0 : sel_ff + 2'd1;

   assign tn   = cur_ff.pos * cur_ff.n;
   assign ll   = (tn[sub_pkg::PIECE_W+sub_pkg::POS_W-1:16] > NW'(cur_ff.n - 1'b1)) ?
                 NW'(cur_ff.n - 1'b1) : tn[sub_pkg::PIECE_W+sub_pkg::POS_W-1:16];
   assign frac = tn - {ll, 16'b0};
   assign pseg = SEGMENT_BITS'(cur_ff.base) + SEGMENT_BITS'(ll);

   always_comb begin
      logic [NW:0] sum;
      logic        carry;
      {ld_neg, ld_mag} = dividend(ld_sel, (state_ff == ST_IDLE) ? pop_item : cur_ff);
      for (int k = 0; k < 3; k++) begin
         sum       = {1'b0, res_ff[k]} + {1'b0, str_ff[k]};
         carry     = (sum >= {1'b0, den});
         res_nx[k] = carry ? NW'(sum - {1'b0, den}) : sum[NW-1:0];
         acc_nx[k] = acc_ff[k] + stq_ff[k] + CW'(carry);
      end
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      out_in       = out_ff;
      out_valid_in = out_valid_ff && !rsp.ready;
      sel_in       = sel_ff;
      cnt_in       = cnt_ff;
      dnum_in      = dnum_ff;
      drem_in      = drem_ff;
      dneg_in      = dneg_ff;
      stq_in       = stq_ff;
      str_in       = str_ff;
      acc_in       = acc_ff;
      res_in       = res_ff;
      j_in         = j_ff;
      vcur_in      = vcur_ff;
      seg_in       = seg_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pop_valid) begin
               cur_in = pop_item;
               if (pop_item.is_point) begin
                  state_in = ST_POINT;
               end else begin
                  state_in = ST_DIV;
                  sel_in   = 2'd0;
                  cnt_in   = '0;
                  dnum_in  = ld_mag;
                  drem_in  = '0;
                  dneg_in  = ld_neg;
               end
            end
         end
         ST_DIV: begin
            dnum_in = q_mag;
            drem_in = r_fin;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 6'(DW - 1)) begin
               stq_in[sel_ff] = q_fix;
               str_in[sel_ff] = r_fix;
               cnt_in         = '0;
               if (sel_ff == 2'd2) begin
                  state_in = ST_EMIT;
                  for (int k = 0; k < 3; k++) begin
                     acc_in[k] = '0;
                     res_in[k] = NW'(cur_ff.n);
                  end
                  j_in    = '0;
                  vcur_in = VERTEX_BITS'(cur_ff.nv);
                  seg_in  = SEGMENT_BITS'(cur_ff.base);
               end else begin
                  sel_in  = ld_sel;
                  dnum_in = ld_mag;
                  drem_in = '0;
                  dneg_in = ld_neg;
               end
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in             = 1'b1;
               out_in                   = '0;
               out_in.kind              = sub_pkg::KIND_SEGMENT;
               out_in.coarse_segment    = cur_ff.cseg;
               out_in.fine_from         = (j_ff == '0) ? sub_pkg::VTX_W'(cur_ff.cf) :
                                          sub_pkg::VTX_W'(vprev);
               out_in.fine_to           = fin ? sub_pkg::VTX_W'(cur_ff.ct) :
                                          sub_pkg::VTX_W'(vcur_ff);
               out_in.new_vertex        = !fin;
               out_in.fine_segment      = sub_pkg::SEG_W'(seg_ff);
               out_in.last              = fin;
               if (!fin) begin
                  out_in.vertex_x   = cur_ff.sx + acc_nx[0];
                  out_in.vertex_y   = cur_ff.sy + acc_nx[1];
                  out_in.vertex_pos = acc_nx[2][sub_pkg::POS_W-1:0];
               end
               acc_in  = acc_nx;
               res_in  = res_nx;
               j_in    = j_ff + 1'b1;
               vcur_in = vcur_ff + VERTEX_BITS'(1);
               seg_in  = seg_ff + SEGMENT_BITS'(1);
               if (fin) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_POINT: begin
            if (out_free) begin
               out_valid_in          = 1'b1;
               out_in                = '0;
               out_in.kind           = sub_pkg::KIND_POINT;
               out_in.coarse_segment = cur_ff.cseg;
               out_in.last           = 1'b1;
               if (cur_ff.n == '0) begin
                  out_in.error = 1'b1;
               end else begin
                  out_in.fine_segment   = sub_pkg::SEG_W'(pseg);
                  out_in.fine_point_pos = (frac > 24'(sub_pkg::Q_ONE)) ? sub_pkg::Q_ONE :
                                          frac[sub_pkg::POS_W-1:0];
               end
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      cur_ff  <= cur_in;
      out_ff  <= out_in;
      sel_ff  <= sel_in;
      cnt_ff  <= cnt_in;
      dnum_ff <= dnum_in;
      drem_ff <= drem_in;
      dneg_ff <= dneg_in;
      stq_ff  <= stq_in;
      str_ff  <= str_in;
      acc_ff  <= acc_in;
      res_ff  <= res_in;
      j_ff    <= j_in;
      vcur_ff <= vcur_in;
      seg_ff  <= seg_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.kind           = out_ff.kind;
   assign rsp.coarse_segment = out_ff.coarse_segment;
   assign rsp.fine_from      = out_ff.fine_from;
   assign rsp.fine_to        = out_ff.fine_to;
   assign rsp.new_vertex     = out_ff.new_vertex;
   assign rsp.vertex_x       = out_ff.vertex_x;
   assign rsp.vertex_y       = out_ff.vertex_y;
   assign rsp.vertex_pos     = out_ff.vertex_pos;
   assign rsp.fine_segment   = out_ff.fine_segment;
   assign rsp.fine_point_pos = out_ff.fine_point_pos;
   assign rsp.last           = out_ff.last;
   assign rsp.error          = out_ff.error;
endmodule

>>> design/sub_checker.sv
// Port-level checks of the segment subdivider and their bind.
`include "segment_subdivider_assert.svh"

module sub_checker (
   input logic clock,
   input logic reset,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_kind,
   input logic rsp_new_vertex,
   input logic rsp_last,
   input logic rsp_error,
   input logic [sub_pkg::VTX_W-1:0] rsp_fine_from
);
   `SUB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `SUB_ASSERT_NOW(a_err_point, rsp_valid && rsp_error, rsp_kind && rsp_last)
   `SUB_ASSERT_NOW(a_point_single, rsp_valid && rsp_kind, rsp_last && rsp_fine_from == '0)
   `SUB_ASSERT_NOW(a_piece_vertex, rsp_valid && !rsp_kind, rsp_new_vertex != rsp_last)
endmodule

bind segment_subdivider sub_checker u_sub_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_bus.valid),
   .rsp_ready      (rsp_bus.ready),
   .rsp_kind       (rsp_bus.kind),
   .rsp_new_vertex (rsp_bus.new_vertex),
   .rsp_last       (rsp_bus.last),
   .rsp_error      (rsp_bus.error),
   .rsp_fine_from  (rsp_bus.fine_from)
);

>>> verif/segment_subdivider_tb.sv
// Self-checking testbench of the segment subdivider: predicted fine segments and mapped points.
module segment_subdivider_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sub_pkg::*;

   class subdiv_scoreboard;
      result_type pending[$];
      int unsigned errors;
      int unsigned results_seen;
      logic [VTX_W-1:0] vertex_base;
      logic [VTX_W-1:0] next_vtx;
      logic [SEG_W-1:0] seg_count;
      logic [CSEG_W-1:0] seg_idx;
      logic [PIECE_W-1:0] cur_n;
      logic [SEG_W-1:0] cur_base;

      function new();
         errors = 0;
         results_seen = 0;
         vertex_base = '0;
         next_vtx = '0;
         seg_count = '0;
         seg_idx = '1;
         cur_n = '0;
         cur_base = '0;
      endfunction

      function void load_vertex_count(logic [VTX_W-1:0] v);
         vertex_base = v;
         next_vtx = v;
      endfunction

      function logic [COORD_W-1:0] interp(longint s, longint e, longint j, longint n);
         longint num;
         longint den;
         longint q;
         num = 2 * j * (e - s) + n;
         den = 2 * n;
         q = num / den;
         if (num % den != 0 && num < 0) q = q - 1;
         return COORD_W'(s + q);
      endfunction

      function void note_request(logic cmd, logic [CSEG_W-1:0] cf, logic [CSEG_W-1:0] ct,
                                 logic signed [31:0] sx, logic signed [31:0] sy,
                                 logic signed [31:0] ex, logic signed [31:0] ey,
                                 logic [PIECE_W-1:0] pieces, logic [POS_W-1:0] pos);
         result_type r;
         int n;
         longint unsigned tn;
         longint unsigned ll;
         longint unsigned frac;
         if (cmd == CMD_SEGMENT) begin
            n = (pieces > 64) ? 64 : pieces;
            seg_idx = seg_idx + 1'b1;
            cur_n = PIECE_W'(n);
            cur_base = seg_count;
            for (int j = 0; j < n; j++) begin
               r = '0;
               r.kind = KIND_SEGMENT;
               r.coarse_segment = seg_idx;
               r.fine_from = (j == 0) ? VTX_W'(cf) : VTX_W'(next_vtx + j - 1);
               r.fine_to = (j + 1 == n) ? VTX_W'(ct) : VTX_W'(next_vtx + j);
               if (j + 1 != n) begin
                  r.new_vertex = 1'b1;
                  r.vertex_x = interp(sx, ex, j + 1, n);
                  r.vertex_y = interp(sy, ey, j + 1, n);
                  r.vertex_pos = POS_W'(((j + 1) * 2 * 65536 + n) / (2 * n));
               end
               r.fine_segment = SEG_W'(cur_base + j);
               r.last = (j + 1 == n);
               pending.push_back(r);
            end
            if (n > 0) begin
               next_vtx = next_vtx + VTX_W'(n - 1);
               seg_count = seg_count + SEG_W'(n);
            end
         end else begin
            r = '0;
            r.kind = KIND_POINT;
            r.coarse_segment = seg_idx;
            r.last = 1'b1;
            if (cur_n == 0) begin
               r.error = 1'b1;
            end else begin
               tn = longint'(pos) * cur_n;
               ll = tn >> 16;
               if (ll > cur_n - 1) ll = cur_n - 1;
               frac = tn - ll * 65536;
               if (frac > 65536) frac = 65536;
               r.fine_segment = SEG_W'(cur_base + ll);
               r.fine_point_pos = POS_W'(frac);
            end
            pending.push_back(r);
         end
      endfunction

      function void check_result(result_type got);
         result_type exp;
         results_seen++;
         if (pending.size() == 0) begin
            $error("unexpected result beat");
            errors++;
            return;
         end
         exp = pending.pop_front();
         if (got.kind !== exp.kind) begin
            $error("kind exp %0h got %0h", exp.kind, got.kind); errors++;
         end
         if (got.coarse_segment !== exp.coarse_segment) begin
            $error("coarse_segment exp %0h got %0h", exp.coarse_segment, got.coarse_segment);
            errors++;
         end
         if (got.fine_from !== exp.fine_from) begin
            $error("fine_from exp %0h got %0h", exp.fine_from, got.fine_from); errors++;
         end
         if (got.fine_to !== exp.fine_to) begin
            $error("fine_to exp %0h got %0h", exp.fine_to, got.fine_to); errors++;
         end
         if (got.new_vertex !== exp.new_vertex) begin
            $error("new_vertex exp %0h got %0h", exp.new_vertex, got.new_vertex); errors++;
         end
         if (got.vertex_x !== exp.vertex_x) begin
            $error("vertex_x exp %0h got %0h", exp.vertex_x, got.vertex_x); errors++;
         end
         if (got.vertex_y !== exp.vertex_y) begin
            $error("vertex_y exp %0h got %0h", exp.vertex_y, got.vertex_y); errors++;
         end
         if (got.vertex_pos !== exp.vertex_pos) begin
            $error("vertex_pos exp %0h got %0h", exp.vertex_pos, got.vertex_pos); errors++;
         end
         if (got.fine_segment !== exp.fine_segment) begin
            $error("fine_segment exp %0h got %0h", exp.fine_segment, got.fine_segment);
            errors++;
         end
         if (got.fine_point_pos !== exp.fine_point_pos) begin
            $error("fine_point_pos exp %0h got %0h", exp.fine_point_pos, got.fine_point_pos);
            errors++;
         end
         if (got.last !== exp.last) begin
            $error("last exp %0h got %0h", exp.last, got.last); errors++;
         end
         if (got.error !== exp.error) begin
            $error("error exp %0h got %0h", exp.error, got.error); errors++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   sub_req_if req_bus();
   sub_rsp_if rsp_bus();
   sub_csr_if csr_bus();
   subdiv_scoreboard board;
   bit calm;
   int unsigned items_sent;
   int unsigned segments_sent;
   int unsigned points_sent;

   segment_subdivider DUT (
      .clock(clock), .reset(reset),
      .req_bus(req_bus.sink), .rsp_bus(rsp_bus.source), .csr_bus(csr_bus.sink)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("** segment_subdivider: FAILED **");
      $finish;
   end

   // sample result beats and pace the response ready in bursts
   initial begin
      int hold;
      rsp_bus.ready = 1'b0;
      hold = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            board.check_result('{rsp_bus.kind, rsp_bus.coarse_segment, rsp_bus.fine_from,
               rsp_bus.fine_to, rsp_bus.new_vertex, rsp_bus.vertex_x, rsp_bus.vertex_y,
               rsp_bus.vertex_pos, rsp_bus.fine_segment, rsp_bus.fine_point_pos,
               rsp_bus.last, rsp_bus.error});
         end
         if (hold > 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(0, 10);
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   task automatic idle_burst();
      int gap;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 11);
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_item(logic cmd, logic [CSEG_W-1:0] cf, logic [CSEG_W-1:0] ct,
                            logic [31:0] sx, logic [31:0] sy, logic [31:0] ex,
                            logic [31:0] ey, logic [PIECE_W-1:0] pieces,
                            logic [POS_W-1:0] pos);
      idle_burst();
      req_bus.valid <= 1'b1;
      req_bus.command <= cmd;
      req_bus.coarse_from <= cf;
      req_bus.coarse_to <= ct;
      req_bus.start_x <= sx;
      req_bus.start_y <= sy;
      req_bus.end_x <= ex;
      req_bus.end_y <= ey;
      req_bus.pieces <= pieces;
      req_bus.point_pos <= pos;
      do @(posedge clock); while (!req_bus.ready);
      board.note_request(cmd, cf, ct, sx, sy, ex, ey, pieces, pos);
      items_sent++;
      if (cmd == CMD_SEGMENT) segments_sent++; else points_sent++;
   endtask

   task automatic send_segment(logic [PIECE_W-1:0] pieces);
      send_item(CMD_SEGMENT, CSEG_W'($urandom), CSEG_W'($urandom), $urandom, $urandom,
                $urandom, $urandom, pieces, POS_W'($urandom));
   endtask

   task automatic send_point(logic [POS_W-1:0] pos);
      send_item(CMD_POINT, CSEG_W'($urandom), CSEG_W'($urandom), $urandom, $urandom,
                $urandom, $urandom, PIECE_W'($urandom), pos);
   endtask

   task automatic write_vertex_count(logic [VTX_W-1:0] v);
      csr_bus.valid <= 1'b1;
      csr_bus.data <= v;
      do @(posedge clock); while (!csr_bus.ready);
      board.load_vertex_count(v);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic drain();
      int guard;
      guard = 0;
      req_bus.valid <= 1'b0;
      while (board.pending.size() != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      if (board.pending.size() != 0) begin
         $display("** segment_subdivider: FAILED **");
         $finish;
      end
      repeat (150) @(posedge clock);
   endtask

   task automatic random_item();
      int pick;
      logic [POS_W-1:0] pos;
      pick = $urandom_range(0, 99);
      pos = ($urandom_range(0, 9) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 65536));
      if (pick < 30) begin
         send_segment(($urandom_range(0, 9) == 0) ? PIECE_W'($urandom)
                                                  : PIECE_W'($urandom_range(0, 8)));
      end else begin
         send_point(pos);
      end
   endtask

   initial begin
      logic [VTX_W-1:0] settings[4];
      board = new();
      calm = 1'b0;
      items_sent = 0;
      segments_sent = 0;
      points_sent = 0;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = CMD_SEGMENT;
      req_bus.coarse_from = '0;
      req_bus.coarse_to = '0;
      req_bus.start_x = '0;
      req_bus.start_y = '0;
      req_bus.end_x = '0;
      req_bus.end_y = '0;
      req_bus.pieces = '0;
      req_bus.point_pos = '0;
      csr_bus.valid = 1'b0;
      csr_bus.data = '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: point before any segment, zero pieces, extremes
      send_point(POS_W'(0));
      send_segment(PIECE_W'(0));
      send_point(POS_W'(65536));
      send_item(CMD_SEGMENT, '0, '1, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                32'h8000_0000, PIECE_W'(1), '0);
      send_point(POS_W'(0));
      send_point(POS_W'(65536));
      send_item(CMD_SEGMENT, '1, '0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                32'h7fff_ffff, PIECE_W'(64), '0);
      send_point(POS_W'(0));
      send_point(POS_W'(65535));
      send_point(POS_W'(65536));
      send_point(POS_W'(131071));
      send_segment(PIECE_W'(127));
      send_point(POS_W'(32768));
      send_item(CMD_SEGMENT, 20'h12345, 20'h54321, 32'h0001_0000, 32'hffff_0000,
                32'h0004_0000, 32'h0002_0000, PIECE_W'(3), '0);
      send_point(POS_W'(21845));
      send_point(POS_W'(43690));
      send_segment(PIECE_W'(65));
      send_point(POS_W'($urandom));
      drain();

      settings = '{VTX_W'(0), VTX_W'(1048576), VTX_W'(2097151), VTX_W'(0)};
      for (int phase = 0; phase < 4; phase++) begin
         settings[3] = VTX_W'($urandom);
         write_vertex_count(settings[phase]);
         if (phase == 3) calm = 1'b1;
         repeat (65) random_item();
         drain();
      end

      $display("sent %0d items (%0d segments, %0d points), checked %0d result beats",
               items_sent, segments_sent, points_sent, board.results_seen);
      $display("vertex count settings covered zero, mid, all ones and random");
      if (board.errors == 0) begin
         $display("** segment_subdivider: PASSED **");
      end else begin
         $display("** segment_subdivider: FAILED **");
      end
      $finish;
   end
endmodule

>>> files.f
+incdir+design
design/sub_pkg.sv
design/sub_channels.sv
design/sub_front.sv
design/sub_queue.sv
design/sub_back.sv
design/segment_subdivider.sv
design/sub_checker.sv
verif/segment_subdivider_tb.sv
